FILE: rtl/core/quaternion_multiply_rotate_unit_defines.svh
// Assertion shorthands for the quaternion unit checkers.
`ifndef QUATERNION_MULTIPLY_ROTATE_UNIT_DEFINES_SVH
`define QUATERNION_MULTIPLY_ROTATE_UNIT_DEFINES_SVH

// Condition now implies consequence in the next cycle.
`define QMR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qmr check failed");

// Condition now implies consequence in the same cycle.
`define QMR_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qmr check failed");

`endif

FILE: rtl/core/qmr_pkg.sv
package qmr_pkg;

   localparam int FRAC_BITS = 28;

   // square root: 65-bit sum padded to 66 bits, one root bit per stage
   localparam int SQ_XW    = 66;
   localparam int SQ_STEPS = SQ_XW / 2;
   localparam int SQ_ROOTW = SQ_STEPS;
   localparam int SQ_RW    = SQ_ROOTW + 4;

   // divider: quotient never exceeds 2^FRAC_BITS
   localparam int QW        = FRAC_BITS + 1;
   localparam int DIV_STEPS = QW;
   localparam int NW        = FRAC_BITS + 33;
   localparam int DREM_W    = SQ_ROOTW;

   localparam int NORM_LAT = SQ_STEPS + 1 + DIV_STEPS;

   // Hamilton product arithmetic
   localparam int PW    = 66;
   localparam int SUM_W = PW + 2;
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

   localparam logic [64:0] UNIT_SQ = 65'(1) << (2 * FRAC_BITS);

   typedef enum logic [1:0] {
      CMD_MUL  = 2'd0,
      CMD_ROT  = 2'd1,
      CMD_NORM = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef struct packed {
      logic signed [31:0] w;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } quat32_type;

   typedef struct packed {
      logic signed [32:0] w;
      logic signed [32:0] x;
      logic signed [32:0] y;
      logic signed [32:0] z;
   } quat33_type;

   typedef logic [3:0][31:0] mag4_type;
   typedef logic [3:0][QW-1:0] quot4_type;

   typedef struct packed {
      logic [SQ_XW-1:0]    x;
      logic [SQ_RW-1:0]    rem;
      logic [SQ_ROOTW-1:0] root;
   } sq_step_type;

   typedef struct packed {
      logic [DREM_W-1:0] rem;
      logic [QW-1:0]     lo;
      logic [QW-1:0]     q;
   } div_lane_type;

   function automatic quat33_type widen(quat32_type q);
      quat33_type o;
      o.w = {q.w[31], q.w};
      o.x = {q.x[31], q.x};
      o.y = {q.y[31], q.y};
      o.z = {q.z[31], q.z};
      return o;
   endfunction

   function automatic quat33_type conj_widen(quat32_type q);
      quat33_type o;
      o = widen(q);
      o.x = -o.x;
      o.y = -o.y;
      o.z = -o.z;
      return o;
   endfunction

endpackage

FILE: rtl/core/qmr_if.sv
interface qmr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [31:0] a_w;
   logic signed [31:0] a_x;
   logic signed [31:0] a_y;
   logic signed [31:0] a_z;
   logic signed [31:0] b_w;
   logic signed [31:0] b_x;
   logic signed [31:0] b_y;
   logic signed [31:0] b_z;

   modport source (output valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                   input ready);
   modport sink (input valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                 output ready);
endinterface

interface qmr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] r_w;
   logic signed [31:0] r_x;
   logic signed [31:0] r_y;
   logic signed [31:0] r_z;
   logic               overflow;

   modport source (output valid, r_w, r_x, r_y, r_z, overflow, input ready);
   modport sink (input valid, r_w, r_x, r_y, r_z, overflow, output ready);
endinterface

FILE: rtl/core/qmr_norm.sv
// Pipelined integer square root followed by four restoring divider lanes.
module qmr_norm (
   input  logic                 clock,
   input  logic                 en,
   input  logic [64:0]          sum_sq,
   input  qmr_pkg::mag4_type    mag,
   output qmr_pkg::quot4_type   quot
);

   qmr_pkg::sq_step_type sq_ff [qmr_pkg::SQ_STEPS];
   qmr_pkg::sq_step_type sq_in [qmr_pkg::SQ_STEPS];
   qmr_pkg::mag4_type    mag_ff [qmr_pkg::SQ_STEPS];
   qmr_pkg::mag4_type    mag_in [qmr_pkg::SQ_STEPS];

   logic [3:0][qmr_pkg::NW-1:0]   num_ff;
   logic [3:0][qmr_pkg::NW-1:0]   num_in;
   logic [qmr_pkg::SQ_ROOTW-1:0]  den_ff;

   qmr_pkg::div_lane_type [3:0]   dv_ff [qmr_pkg::DIV_STEPS];
   qmr_pkg::div_lane_type [3:0]   dv_in [qmr_pkg::DIV_STEPS];
   logic [qmr_pkg::SQ_ROOTW-1:0]  dd_ff [qmr_pkg::DIV_STEPS];

   function automatic qmr_pkg::sq_step_type sq_step(qmr_pkg::sq_step_type s);
      logic [qmr_pkg::SQ_RW-1:0] rsh;
      logic [qmr_pkg::SQ_RW-1:0] trial;
      qmr_pkg::sq_step_type      o;
      rsh   = {s.rem[qmr_pkg::SQ_RW-3:0], s.x[qmr_pkg::SQ_XW-1 -: 2]};
      trial = {{(qmr_pkg::SQ_RW - qmr_pkg::SQ_ROOTW - 2){1'b0}}, s.root, 2'b01};
      o.x   = {s.x[qmr_pkg::SQ_XW-3:0], 2'b00};
      if (rsh >= trial) begin
         o.rem  = rsh - trial;
         o.root = {s.root[qmr_pkg::SQ_ROOTW-2:0], 1'b1};
      end else begin
         o.rem  = rsh;
         o.root = {s.root[qmr_pkg::SQ_ROOTW-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic qmr_pkg::div_lane_type div_step(qmr_pkg::div_lane_type l,
                                                      logic [qmr_pkg::SQ_ROOTW-1:0] d);
      logic [qmr_pkg::DREM_W:0] rsh;
      logic [qmr_pkg::DREM_W:0] dx;
      logic                     qbit;
      qmr_pkg::div_lane_type    o;
      rsh  = {l.rem, l.lo[qmr_pkg::QW-1]};
      dx   = {1'b0, d};
      qbit = (rsh >= dx);
      if (qbit) begin
         o.rem = qmr_pkg::DREM_W'(rsh - dx);
      end else begin
         o.rem = qmr_pkg::DREM_W'(rsh);
      end
      o.lo = {l.lo[qmr_pkg::QW-2:0], 1'b0};
      o.q  = {l.q[qmr_pkg::QW-2:0], qbit};
      return o;
   endfunction

   always_comb begin
      qmr_pkg::sq_step_type  seed;
      qmr_pkg::div_lane_type init;
      seed.x    = {1'b0, sum_sq};
      seed.rem  = '0;
      seed.root = '0;
      sq_in[0]  = sq_step(seed);
      mag_in[0] = mag;
      for (int k = 1; k < qmr_pkg::SQ_STEPS; k++) begin
         sq_in[k]  = sq_step(sq_ff[k-1]);
         mag_in[k] = mag_ff[k-1];
      end

      // numerator: c * 2^F plus half the root, for round to nearest
      for (int j = 0; j < 4; j++) begin
         num_in[j] = {1'b0, mag_ff[qmr_pkg::SQ_STEPS-1][j], {qmr_pkg::FRAC_BITS{1'b0}}}
                     + qmr_pkg::NW'(sq_ff[qmr_pkg::SQ_STEPS-1].root >> 1);
      end

      for (int j = 0; j < 4; j++) begin
         init.rem   = {1'b0, num_ff[j][qmr_pkg::NW-1:qmr_pkg::QW]};
         init.lo    = num_ff[j][qmr_pkg::QW-1:0];
         init.q     = '0;
         dv_in[0][j] = div_step(init, den_ff);
      end
      for (int k = 1; k < qmr_pkg::DIV_STEPS; k++) begin
         for (int j = 0; j < 4; j++) begin
            dv_in[k][j] = div_step(dv_ff[k-1][j], dd_ff[k-1]);
         end
      end

      for (int j = 0; j < 4; j++) begin
         quot[j] = dv_ff[qmr_pkg::DIV_STEPS-1][j].q;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= sq_in;
         mag_ff   <= mag_in;
         num_ff   <= num_in;
         den_ff   <= sq_ff[qmr_pkg::SQ_STEPS-1].root;
         dv_ff    <= dv_in;
         dd_ff[0] <= den_ff;
         for (int k = 1; k < qmr_pkg::DIV_STEPS; k++) begin
            dd_ff[k] <= dd_ff[k-1];
         end
      end
   end

endmodule

FILE: rtl/core/qmr_hamilton.sv
// Two-stage Hamilton product: products registered, then fold, round, saturate.
module qmr_hamilton (
   input  logic                 clock,
   input  logic                 en,
   input  qmr_pkg::quat33_type  op_a,
   input  qmr_pkg::quat33_type  op_b,
   output qmr_pkg::quat32_type  result,
   output logic                 ovf
);

   logic signed [qmr_pkg::PW-1:0] prod_ff [16];
   logic signed [qmr_pkg::PW-1:0] prod_in [16];
   qmr_pkg::quat32_type           res_ff;
   qmr_pkg::quat32_type           res_in;
   logic                          ovf_ff;
   logic                          ovf_in;

   function automatic logic [qmr_pkg::SUM_W-1:0] sx(logic [qmr_pkg::PW-1:0] p);
      return {{(qmr_pkg::SUM_W - qmr_pkg::PW){p[qmr_pkg::PW-1]}}, p};
   endfunction

   // returns {saturated, value}
   function automatic logic [32:0] fold(logic [qmr_pkg::SUM_W-1:0] sum);
      logic signed [qmr_pkg::SUM_W-1:0] rnd;
      logic signed [qmr_pkg::SUM_W-1:0] sh;
      logic [qmr_pkg::SUM_W-32:0]       upper;
      rnd   = sum + qmr_pkg::ROUND_HALF;
      sh    = rnd >>> qmr_pkg::FRAC_BITS;
      upper = sh[qmr_pkg::SUM_W-1:31];
      if ((&upper) || !(|upper)) begin
         return {1'b0, sh[31:0]};
      end else if (sh[qmr_pkg::SUM_W-1]) begin
         return {1'b1, 32'h8000_0000};
      end else begin
         return {1'b1, 32'h7fff_ffff};
      end
   endfunction

   always_comb begin
      prod_in[0]  = op_a.w * op_b.w;
      prod_in[1]  = op_a.x * op_b.x;
      prod_in[2]  = op_a.y * op_b.y;
      prod_in[3]  = op_a.z * op_b.z;
      prod_in[4]  = op_a.w * op_b.x;
      prod_in[5]  = op_a.x * op_b.w;
      prod_in[6]  = op_a.y * op_b.z;
      prod_in[7]  = op_a.z * op_b.y;
      prod_in[8]  = op_a.w * op_b.y;
      prod_in[9]  = op_a.y * op_b.w;
      prod_in[10] = op_a.z * op_b.x;
      prod_in[11] = op_a.x * op_b.z;
      prod_in[12] = op_a.w * op_b.z;
      prod_in[13] = op_a.z * op_b.w;
      prod_in[14] = op_a.x * op_b.y;
      prod_in[15] = op_a.y * op_b.x;
   end

   always_comb begin
      logic [32:0] fw;
      logic [32:0] fx;
      logic [32:0] fy;
      logic [32:0] fz;
      fw = fold(sx(prod_ff[0]) - sx(prod_ff[1]) - sx(prod_ff[2]) - sx(prod_ff[3]));
      fx = fold(sx(prod_ff[4]) + sx(prod_ff[5]) + sx(prod_ff[6]) - sx(prod_ff[7]));
      fy = fold(sx(prod_ff[8]) + sx(prod_ff[9]) + sx(prod_ff[10]) - sx(prod_ff[11]));
      fz = fold(sx(prod_ff[12]) + sx(prod_ff[13]) + sx(prod_ff[14]) - sx(prod_ff[15]));
      res_in.w = fw[31:0];
      res_in.x = fx[31:0];
      res_in.y = fy[31:0];
      res_in.z = fz[31:0];
      ovf_in   = fw[32] | fx[32] | fy[32] | fz[32];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         res_ff  <= res_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign result = res_ff;
   assign ovf    = ovf_ff;

endmodule

FILE: rtl/core/quaternion_multiply_rotate_unit.sv
// Data is Q3.28. Throughput: one item per clock while the skid is empty;
// the square root (one root bit per stage, 33 stages) and the dividers (one
// quotient bit per stage) are fully pipelined. A one-entry skid behind the
// output register keeps a stalled result while the next item is taken; a
// second stalled result halts the pipeline. Reset (synchronous) clears valid
// bits and the skid; no data is cleared.
module quaternion_multiply_rotate_unit (
   input  logic       clock,
   input  logic       reset,
   qmr_req_if.sink    req_chan,
   qmr_rsp_if.source  rsp_chan
);

   localparam int PIPE_LEN = qmr_pkg::NORM_LAT + 9;

   // operand bundle that rides alongside the root and divider pipeline
   typedef struct packed {
      qmr_pkg::cmd_type    cmd;
      qmr_pkg::quat32_type a;
      qmr_pkg::quat32_type b;
      logic [3:0]          neg;
      logic                s_zero;
      logic                s_unit;
   } side_type;

   typedef struct packed {
      side_type            side;
      logic [3:0][63:0]    sq;
      qmr_pkg::mag4_type   mag;
   } sq_stage_type;

   typedef struct packed {
      side_type            side;
      logic [64:0]         sum;
      qmr_pkg::mag4_type   mag;
   } sum_stage_type;

   typedef struct packed {
      qmr_pkg::cmd_type    cmd;
      qmr_pkg::quat32_type a;
      qmr_pkg::quat32_type nres;
   } mid_type;

   typedef struct packed {
      qmr_pkg::cmd_type    cmd;
      qmr_pkg::quat32_type nres;
      qmr_pkg::quat32_type r1;
      logic                ovf1;
   } tail_type;

   typedef struct packed {
      qmr_pkg::quat32_type r;
      logic                ovf;
   } out_type;

   // control
   logic                    en;
   logic                    accept;
   logic [PIPE_LEN-1:0]     vld_ff;
   logic                    rsp_vld_ff;
   logic                    skid_vld_ff;

   // payload
   side_type                in_ff;
   sq_stage_type            sqs_ff;
   sq_stage_type            sqs_in;
   sum_stage_type           sum_ff;
   sum_stage_type           sum_in;
   side_type                dl_ff [qmr_pkg::NORM_LAT];
   qmr_pkg::quot4_type      quot;
   mid_type                 mid_ff;
   mid_type                 mid_in;
   qmr_pkg::quat33_type     h1a_ff;
   qmr_pkg::quat33_type     h1a_in;
   qmr_pkg::quat33_type     h1b_ff;
   qmr_pkg::quat33_type     h1b_in;
   mid_type                 h1s_ff [2];
   qmr_pkg::quat32_type     t_q;
   logic                    t_ovf;
   tail_type                h2s_ff [2];
   qmr_pkg::quat32_type     r2_q;
   logic                    r2_ovf;
   out_type                 sout_ff;
   out_type                 sout_in;
   out_type                 rsp_ff;
   out_type                 skid_ff;

   // whole pipeline moves unless the skid holds a result
   assign en     = !skid_vld_ff;
   assign accept = req_chan.valid && en;
   assign req_chan.ready = en;

   // stage 1: pick the components to normalise, square them
   always_comb begin
      logic signed [31:0] c [4];
      logic signed [63:0] sqv;
      sqs_in.side = in_ff;
      if (in_ff.cmd == qmr_pkg::CMD_NORM) begin
         c[0] = in_ff.a.w;
         c[1] = in_ff.a.x;
         c[2] = in_ff.a.y;
         c[3] = in_ff.a.z;
      end else begin
         c[0] = '0;
         c[1] = in_ff.b.x;
         c[2] = in_ff.b.y;
         c[3] = in_ff.b.z;
      end
      for (int j = 0; j < 4; j++) begin
         sqv               = c[j] * c[j];
         sqs_in.sq[j]      = sqv;
         sqs_in.mag[j]     = c[j][31] ? 32'(-c[j]) : c[j];
         sqs_in.side.neg[j] = c[j][31];
      end
   end

   // stage 2: sum of squares, exact; 2^64 only when a is all most-negative
   always_comb begin
      sum_in.side = sqs_ff.side;
      sum_in.mag  = sqs_ff.mag;
      sum_in.sum  = 65'(sqs_ff.sq[0]) + 65'(sqs_ff.sq[1])
                  + 65'(sqs_ff.sq[2]) + 65'(sqs_ff.sq[3]);
      sum_in.side.s_zero = (sum_in.sum == '0);
      sum_in.side.s_unit = (sum_in.sum == qmr_pkg::UNIT_SQ);
   end

   qmr_norm u_norm (
      .clock  (clock),
      .en     (en),
      .sum_sq (sum_ff.sum),
      .mag    (sum_ff.mag),
      .quot   (quot)
   );

   // after the divider: signed unit components, operands for the first product
   always_comb begin
      side_type            sd;
      logic signed [31:0]  qs [4];
      logic [31:0]         qz;
      qmr_pkg::quat32_type v;
      sd = dl_ff[qmr_pkg::NORM_LAT-1];
      for (int j = 0; j < 4; j++) begin
         qz    = {{(32 - qmr_pkg::QW){1'b0}}, quot[j]};
         qs[j] = sd.neg[j] ? -qz : qz;
      end

      mid_in.cmd = sd.cmd;
      mid_in.a   = sd.a;
      // zero and exactly-unit quaternions come back untouched
      if (sd.s_zero || sd.s_unit) begin
         mid_in.nres = sd.a;
      end else begin
         mid_in.nres.w = qs[0];
         mid_in.nres.x = qs[1];
         mid_in.nres.y = qs[2];
         mid_in.nres.z = qs[3];
      end

      // zero vector is rotated as given
      v.w = '0;
      if (sd.s_zero) begin
         v.x = sd.b.x;
         v.y = sd.b.y;
         v.z = sd.b.z;
      end else begin
         v.x = qs[1];
         v.y = qs[2];
         v.z = qs[3];
      end

      if (sd.cmd == qmr_pkg::CMD_MUL) begin
         h1a_in = qmr_pkg::widen(sd.a);
         h1b_in = qmr_pkg::widen(sd.b);
      end else begin
         h1a_in = qmr_pkg::widen(v);
         h1b_in = qmr_pkg::conj_widen(sd.a);
      end
   end

   // first product: a*b, or v*conj(a) for a rotation
   qmr_hamilton u_ham_first (
      .clock  (clock),
      .en     (en),
      .op_a   (h1a_ff),
      .op_b   (h1b_ff),
      .result (t_q),
      .ovf    (t_ovf)
   );

   // second product: a*t
   qmr_hamilton u_ham_second (
      .clock  (clock),
      .en     (en),
      .op_a   (qmr_pkg::widen(h1s_ff[1].a)),
      .op_b   (qmr_pkg::widen(t_q)),
      .result (r2_q),
      .ovf    (r2_ovf)
   );

   always_comb begin
      tail_type tl;
      tl = h2s_ff[1];
      case (tl.cmd)
         qmr_pkg::CMD_MUL: begin
            sout_in.r   = tl.r1;
            sout_in.ovf = tl.ovf1;
         end
         qmr_pkg::CMD_ROT: begin
            sout_in.r   = r2_q;
            sout_in.r.w = '0;
            sout_in.ovf = tl.ovf1 | r2_ovf;
         end
         qmr_pkg::CMD_NORM: begin
            sout_in.r   = tl.nres;
            sout_in.ovf = 1'b0;
         end
         default: begin
            sout_in.r   = '0;
            sout_in.ovf = 1'b0;
         end
      endcase
   end

   // payload pipeline, advanced as one
   always_ff @(posedge clock) begin
      if (en) begin
         in_ff.cmd    <= qmr_pkg::cmd_type'(req_chan.command);
         in_ff.a.w    <= req_chan.a_w;
         in_ff.a.x    <= req_chan.a_x;
         in_ff.a.y    <= req_chan.a_y;
         in_ff.a.z    <= req_chan.a_z;
         in_ff.b.w    <= req_chan.b_w;
         in_ff.b.x    <= req_chan.b_x;
         in_ff.b.y    <= req_chan.b_y;
         in_ff.b.z    <= req_chan.b_z;
         in_ff.neg    <= '0;
         in_ff.s_zero <= 1'b0;
         in_ff.s_unit <= 1'b0;
         sqs_ff       <= sqs_in;
         sum_ff       <= sum_in;
         dl_ff[0]     <= sum_ff.side;
         for (int k = 1; k < qmr_pkg::NORM_LAT; k++) begin
            dl_ff[k] <= dl_ff[k-1];
         end
         mid_ff       <= mid_in;
         h1a_ff       <= h1a_in;
         h1b_ff       <= h1b_in;
         h1s_ff[0]    <= mid_ff;
         h1s_ff[1]    <= h1s_ff[0];
         h2s_ff[0]    <= '{cmd: h1s_ff[1].cmd, nres: h1s_ff[1].nres, r1: t_q, ovf1: t_ovf};
         h2s_ff[1]    <= h2s_ff[0];
         sout_ff      <= sout_in;
      end
   end

   // valid bits travel with the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LEN-2:0], accept};
      end
   end

   // output register with one-item skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_chan.ready) begin
            rsp_ff      <= skid_ff;
            rsp_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (!rsp_vld_ff || rsp_chan.ready) begin
         rsp_ff     <= sout_ff;
         rsp_vld_ff <= vld_ff[PIPE_LEN-1];
      end else if (vld_ff[PIPE_LEN-1]) begin
         skid_ff     <= sout_ff;
         skid_vld_ff <= 1'b1;
      end
   end

   assign rsp_chan.valid    = rsp_vld_ff;
   assign rsp_chan.r_w      = rsp_ff.r.w;
   assign rsp_chan.r_x      = rsp_ff.r.x;
   assign rsp_chan.r_y      = rsp_ff.r.y;
   assign rsp_chan.r_z      = rsp_ff.r.z;
   assign rsp_chan.overflow = rsp_ff.ovf;

endmodule

FILE: rtl/core/qmr_checker.sv
`include "quaternion_multiply_rotate_unit_defines.svh"

module qmr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_r_w,
   input logic [31:0] rsp_r_x,
   input logic [31:0] rsp_r_y,
   input logic [31:0] rsp_r_z,
   input logic        rsp_overflow
);

   // a stalled result stays offered
   `QMR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // and unchanged
   `QMR_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable({rsp_r_w, rsp_r_x, rsp_r_y, rsp_r_z, rsp_overflow}))

   // input back-pressure only follows a stalled output item
   `QMR_ASSERT_SAME(a_stall_cause, !req_ready, $past(rsp_valid && !rsp_ready))

   // taking an item always frees the input side
   `QMR_ASSERT_NEXT(a_drain_frees, rsp_valid && rsp_ready, req_ready)

endmodule

bind quaternion_multiply_rotate_unit qmr_checker u_qmr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_r_w      (rsp_chan.r_w),
   .rsp_r_x      (rsp_chan.r_x),
   .rsp_r_y      (rsp_chan.r_y),
   .rsp_r_z      (rsp_chan.r_z),
   .rsp_overflow (rsp_chan.overflow)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int N_RANDOM   = 1300;
   localparam int CALM_ITEMS = 200;     // no idling over the closing stretch
   localparam int DRAIN_WAIT = 120;     // longer than the pipeline latency
   localparam int STALL_LIMIT = 5000;   // cycles without any accept on either side
   localparam logic signed [31:0] ONE  = 32'sh1000_0000;
   localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] SMIN = 32'sh8000_0000;

   typedef logic signed [127:0] wide_type;
   typedef struct {
      wide_type w, x, y, z;
   } quatw_type;

   typedef struct {
      qmr_pkg::cmd_type    cmd;
      qmr_pkg::quat32_type a;
      qmr_pkg::quat32_type b;
   } op_type;

   typedef struct packed {
      logic signed [31:0] w, x, y, z;
      logic               ovf;
   } result_type;

   typedef struct {
      op_type     op;
      bit         fixed;   // expected result typed in below
      result_type res;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qmr_req_if req_chan ();
   qmr_rsp_if rsp_chan ();

   quaternion_multiply_rotate_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   result_type pending_results[$];
   int         mismatches = 0;
   bit         calm = 1'b0;

   // ---------------------------------------------------------------------
   // Predictor: exact wide arithmetic, round half up, saturate to 32 bits
   // ---------------------------------------------------------------------
   function automatic wide_type round_sat(wide_type sum, inout bit ovf);
      wide_type v;
      v = (sum + (wide_type'(1) <<< (qmr_pkg::FRAC_BITS - 1))) >>> qmr_pkg::FRAC_BITS;
      if (v > wide_type'(SMAX)) begin
         ovf = 1'b1;
         return wide_type'(SMAX);
      end
      if (v < wide_type'(SMIN)) begin
         ovf = 1'b1;
         return wide_type'(SMIN);
      end
      return v;
   endfunction

   function automatic quatw_type hamilton_product(quatw_type p, quatw_type q,
                                                  inout bit ovf);
      quatw_type r;
      r.w = round_sat(p.w*q.w - p.x*q.x - p.y*q.y - p.z*q.z, ovf);
      r.x = round_sat(p.w*q.x + p.x*q.w + p.y*q.z - p.z*q.y, ovf);
      r.y = round_sat(p.w*q.y + p.y*q.w + p.z*q.x - p.x*q.z, ovf);
      r.z = round_sat(p.w*q.z + p.z*q.w + p.x*q.y - p.y*q.x, ovf);
      return r;
   endfunction

   function automatic wide_type floor_sqrt(wide_type s);
      wide_type res, bitv, x;
      res  = 0;
      x    = s;
      bitv = wide_type'(1) <<< 64;
      while (bitv > x) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >>> 1) + bitv;
         end else begin
            res = res >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return res;
   endfunction

   // c / root at the fixed-point scale, nearest with ties away from zero
   function automatic wide_type scale_div(wide_type c, wide_type root);
      wide_type n, q;
      n = (c < 0) ? -c : c;
      q = ((n <<< qmr_pkg::FRAC_BITS) + (root >>> 1)) / root;
      return (c < 0) ? -q : q;
   endfunction

   function automatic quatw_type widen_q(qmr_pkg::quat32_type q);
      quatw_type o;
      o.w = wide_type'(q.w);
      o.x = wide_type'(q.x);
      o.y = wide_type'(q.y);
      o.z = wide_type'(q.z);
      return o;
   endfunction

   function automatic result_type predict_result(op_type op);
      quatw_type  a, b, t, cj, r;
      wide_type   s, root;
      bit         ovf;
      result_type o;
      ovf = 1'b0;
      a   = widen_q(op.a);
      b   = widen_q(op.b);
      r   = '{0, 0, 0, 0};
      case (op.cmd)
         qmr_pkg::CMD_MUL: begin
            r = hamilton_product(a, b, ovf);
         end
         qmr_pkg::CMD_ROT: begin
            // b_w is ignored; a zero vector goes through untouched
            b.w = 0;
            s = b.x*b.x + b.y*b.y + b.z*b.z;
            if (s != 0) begin
               root = floor_sqrt(s);
               b.x = scale_div(b.x, root);
               b.y = scale_div(b.y, root);
               b.z = scale_div(b.z, root);
            end
            cj = '{a.w, -a.x, -a.y, -a.z};
            t  = hamilton_product(b, cj, ovf);
            r  = hamilton_product(a, t, ovf);
            r.w = 0;   // saturation of the scalar still counts as overflow
         end
         qmr_pkg::CMD_NORM: begin
            s = a.w*a.w + a.x*a.x + a.y*a.y + a.z*a.z;
            r = a;
            if (s != 0 && s != (wide_type'(1) <<< (2*qmr_pkg::FRAC_BITS))) begin
               // all four at -2^31 gives 2^64, whose floor root is 2^32 anyway
               root = floor_sqrt(s);
               r.w = scale_div(a.w, root);
               r.x = scale_div(a.x, root);
               r.y = scale_div(a.y, root);
               r.z = scale_div(a.z, root);
            end
         end
         default: ;   // unused command: all zero
      endcase
      o.w   = r.w[31:0];
      o.x   = r.x[31:0];
      o.y   = r.y[31:0];
      o.z   = r.z[31:0];
      o.ovf = ovf;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic signed [31:0] pick_component();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3, 4, 5, 6: return $signed($urandom_range(0, 32'h2000_0000)) - ONE;
         7: return $signed($urandom_range(0, 32)) - 16;
         default: begin
            case ($urandom_range(0, 6))
               0: return SMIN;
               1: return SMAX;
               2: return ONE;
               3: return -ONE;
               4: return 32'sd1;
               5: return -32'sd1;
               default: return 32'sd0;
            endcase
         end
      endcase
   endfunction

   function automatic qmr_pkg::quat32_type pick_quat();
      qmr_pkg::quat32_type q;
      q.w = pick_component();
      q.x = pick_component();
      q.y = pick_component();
      q.z = pick_component();
      // now and then an exact unit or zero quaternion
      if ($urandom_range(0, 15) == 0) begin
         q = '0;
         case ($urandom_range(0, 4))
            0: q.w = $urandom_range(0, 1) ? ONE : -ONE;
            1: q.x = $urandom_range(0, 1) ? ONE : -ONE;
            2: q.y = $urandom_range(0, 1) ? ONE : -ONE;
            3: q.z = $urandom_range(0, 1) ? ONE : -ONE;
            default: ;
         endcase
      end
      return q;
   endfunction

   function automatic op_type random_op();
      op_type op;
      case ($urandom_range(0, 15))
         0: op.cmd = qmr_pkg::CMD_NONE;
         1, 2, 3, 4, 5: op.cmd = qmr_pkg::CMD_MUL;
         6, 7, 8, 9, 10: op.cmd = qmr_pkg::CMD_ROT;
         default: op.cmd = qmr_pkg::CMD_NORM;
      endcase
      op.a = pick_quat();
      op.b = pick_quat();
      if (op.cmd == qmr_pkg::CMD_ROT && $urandom_range(0, 15) == 0) begin
         op.b.x = 0;   // zero vector to rotate
         op.b.y = 0;
         op.b.z = 0;
      end
      return op;
   endfunction

   // Offer one item and hold it until the unit takes it.
   task automatic send_item(op_type op, bit may_idle);
      if (may_idle && !calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.command <= op.cmd;
      req_chan.a_w <= op.a.w;
      req_chan.a_x <= op.a.x;
      req_chan.a_y <= op.a.y;
      req_chan.a_z <= op.a.z;
      req_chan.b_w <= op.b.w;
      req_chan.b_x <= op.b.x;
      req_chan.b_y <= op.b.y;
      req_chan.b_z <= op.b.z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic row_type mk_row(qmr_pkg::cmd_type cmd, qmr_pkg::quat32_type a,
                                      qmr_pkg::quat32_type b, bit fixed,
                                      result_type res);
      row_type r;
      r.op.cmd = cmd;
      r.op.a   = a;
      r.op.b   = b;
      r.fixed  = fixed;
      r.res    = res;
      return r;
   endfunction

   row_type directed[$];

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   initial begin
      qmr_pkg::quat32_type qz, qone, qmax, qmin, qxone;
      row_type             row;
      op_type              op;
      result_type          zero_res;

      qz    = '0;
      qone  = '{ONE, 0, 0, 0};
      qxone = '{0, ONE, 0, 0};
      qmax  = '{SMAX, SMAX, SMAX, SMAX};
      qmin  = '{SMIN, SMIN, SMIN, SMIN};
      zero_res = '0;

      // rows with a typed expectation: read straight off the arithmetic
      directed.push_back(mk_row(qmr_pkg::CMD_MUL,  qz,   qz,   1, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_MUL,  qone, qmax, 1,
                                '{SMAX, SMAX, SMAX, SMAX, 1'b0}));
      directed.push_back(mk_row(qmr_pkg::CMD_MUL,  qone, qmin, 1,
                                '{SMIN, SMIN, SMIN, SMIN, 1'b0}));
      directed.push_back(mk_row(qmr_pkg::CMD_NONE, qmax, qmin, 1, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_NORM, qz,   qmax, 1, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_NORM, qone, qz,   1, '{ONE, 0, 0, 0, 1'b0}));
      directed.push_back(mk_row(qmr_pkg::CMD_NORM, qmin, qz,   1,
                                '{32'shf800_0000, 32'shf800_0000,
                                  32'shf800_0000, 32'shf800_0000, 1'b0}));
      directed.push_back(mk_row(qmr_pkg::CMD_ROT,  qone, qxone, 1, '{0, ONE, 0, 0, 1'b0}));
      directed.push_back(mk_row(qmr_pkg::CMD_ROT,  qone, qz,   1, zero_res));
      // predictor-checked rows, with two typed rows at the end
      directed.push_back(mk_row(qmr_pkg::CMD_MUL,  qmax, qmax, 0, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_MUL,  qmin, qmin, 0, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_MUL,  qmax, qmin, 0, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_MUL,  '{0, ONE, 0, 0}, '{0, 0, ONE, 0},
                                0, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_ROT,  qmax, qmin, 0, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_ROT,  qmin, qmax, 0, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_ROT,
                                '{32'sh0b50_4f33, 0, 0, 32'sh0b50_4f33},
                                qxone, 0, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_ROT,  qone, '{0, 1, -1, 1}, 0, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_NORM, qmax, qz,   0, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_NORM, '{1, 0, 0, 0}, qz, 0, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_NORM, '{-1, 1, -1, 1}, qz, 0, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_NORM, '{SMIN, SMIN, SMIN, SMAX}, qz,
                                0, zero_res));
      directed.push_back(mk_row(qmr_pkg::CMD_NORM, '{0, 0, -ONE, 0}, qz, 1,
                                '{0, 0, -ONE, 0, 1'b0}));
      directed.push_back(mk_row(qmr_pkg::CMD_NONE, qz, qz, 1, zero_res));

      req_chan.valid   <= 1'b0;
      req_chan.command <= qmr_pkg::CMD_MUL;
      req_chan.a_w <= '0;
      req_chan.a_x <= '0;
      req_chan.a_y <= '0;
      req_chan.a_z <= '0;
      req_chan.b_w <= '0;
      req_chan.b_x <= '0;
      req_chan.b_y <= '0;
      req_chan.b_z <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         row = directed[i];
         send_item(row.op, 1'b1);
         pending_results.push_back(row.fixed ? row.res : predict_result(row.op));
      end

      // hold off until the pipe is empty, then go random
      wait_drained();

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 2) wait_drained();
         if (n == N_RANDOM - CALM_ITEMS) calm = 1'b1;
         op = random_op();
         send_item(op, 1'b1);
         pending_results.push_back(predict_result(op));
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random back-pressure bursts, result check
   // ---------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.r_w, rsp_chan.r_x, rsp_chan.r_y, rsp_chan.r_z,
                    rsp_chan.overflow};
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result w=%h x=%h y=%h z=%h ovf=%b",
                           got.w, got.x, got.y, got.z, got.ovf);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: want w=%h x=%h y=%h z=%h ovf=%b, ",
                               "got w=%h x=%h y=%h z=%h ovf=%b"},
                              want.w, want.x, want.y, want.z, want.ovf,
                              got.w, got.x, got.y, got.z, got.ovf);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);   // start a back-pressure burst
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: nothing moving on either channel for too long
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

FILE: quaternion_multiply_rotate_unit.f
+incdir+rtl/core
rtl/core/qmr_pkg.sv
rtl/core/qmr_if.sv
rtl/core/qmr_norm.sv
rtl/core/qmr_hamilton.sv
rtl/core/quaternion_multiply_rotate_unit.sv
rtl/core/qmr_checker.sv
sim/tb.sv
